### hw/rtl/yhpb_pkg.sv
// shared constants, codes and helper functions for the ymodem header packet builder
// no dependencies
package yhpb_pkg;

	localparam int MAX_PAYLOAD = 1024;
	localparam int AW = $clog2(MAX_PAYLOAD);
	localparam int CW = 11;
	localparam logic [4:0] TOP_POW = 5'd18;

	typedef enum logic [1:0] {
		MODE_NAME = 2'd0,
		MODE_INFO = 2'd1,
		MODE_PULL = 2'd2,
		MODE_END  = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIG  = 5'b00010,
		ST_SPC  = 5'b00100,
		ST_CRC  = 5'b01000,
		ST_PULL = 5'b10000
	} state_t;

	localparam logic [7:0] BYTE_SOH = 8'h01;
	localparam logic [7:0] BYTE_STX = 8'h02;
	localparam logic [7:0] BYTE_NUL = 8'h00;
	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_ZERO_CHAR = 8'h30;

	function automatic logic [CW-1:0] plen(input logic big);
		logic [CW-1:0] n;
		n = big ? CW'(1024) : CW'(128);
		if (n > CW'(MAX_PAYLOAD))
			n = CW'(MAX_PAYLOAD);
		return n;
	endfunction

	function automatic logic [62:0] pow10(input logic [4:0] k);
		logic [62:0] p;
		case (k)
			5'd0:  p = 63'd1;
			5'd1:  p = 63'd10;
			5'd2:  p = 63'd100;
			5'd3:  p = 63'd1000;
			5'd4:  p = 63'd10000;
			5'd5:  p = 63'd100000;
			5'd6:  p = 63'd1000000;
			5'd7:  p = 63'd10000000;
			5'd8:  p = 63'd100000000;
			5'd9:  p = 63'd1000000000;
			5'd10: p = 63'd10000000000;
			5'd11: p = 63'd100000000000;
			5'd12: p = 63'd1000000000000;
			5'd13: p = 63'd10000000000000;
			5'd14: p = 63'd100000000000000;
			5'd15: p = 63'd1000000000000000;
			5'd16: p = 63'd10000000000000000;
			5'd17: p = 63'd100000000000000000;
			5'd18: p = 63'd1000000000000000000;
			default: p = 63'd1;
		endcase
		return p;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		end
		return c;
	endfunction

endpackage

### hw/rtl/ymodem_header_packet_builder_top.sv
// ymodem block-0 header packet builder: payload store, decimal sequencer, crc, byte reader
// depends on yhpb_pkg
// name byte, end packet: taken in idle; pull reads payload bytes from the store read port
// file info build: stores a nul, resolves each decimal digit position (19 positions per
// number, one 63-bit compare and subtract per cycle), stores the space, then runs a
// byte-wide crc over the payload length through the registered store read
// reset is asynchronous and clears control state; the fill count masks stale store entries,
// so there is no clearing pass
module ymodem_header_packet_builder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  name_byte,
	input  logic [62:0] file_size,
	input  logic [62:0] mod_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  packet_byte,
	output logic        last_byte,
	output logic        truncated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        payload_1k
);
	import yhpb_pkg::*;

	state_t state_q;
	logic [CW-1:0] fill_q, ri_q, ci_q, crc_idx_s1;
	logic ovf_q, ready_q, payload_1k_q, built_1k_q, out_valid_q, crc_vld_s1;
	logic [15:0] crc_q;
	logic [62:0] val_q, time_q;
	logic [4:0] k_q;
	logic [3:0] dcnt_q;
	logic started_q, which_q;
	logic [7:0] rdata_q, out_byte_q;
	logic out_last_q, out_trunc_q;
	logic [7:0] mem [MAX_PAYLOAD];

	logic in_fire;
	logic [CW-1:0] lim, lim_cur, lim_bld, fb, fill_n;
	logic ob, ovf_n, put, put_ok, ge, emit;
	logic [7:0] pd, pull_byte, crc_in;
	logic pull_last;
	logic [62:0] pw;
	logic [AW-1:0] ra;
	logic [CW-1:0] pidx;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign packet_byte = out_byte_q;
	assign last_byte = out_last_q;
	assign truncated = out_trunc_q;

	assign lim_cur = plen(payload_1k_q);
	assign lim_bld = plen(built_1k_q);
	assign pw = pow10(k_q);
	assign ge = (val_q >= pw);
	assign emit = !ge && (dcnt_q != 4'd0 || started_q || k_q == 5'd0);
	assign pidx = ri_q - CW'(3);
	assign ra = (state_q == ST_CRC) ? ci_q[AW-1:0] : pidx[AW-1:0];
	assign crc_in = (crc_idx_s1 < fill_q) ? rdata_q : BYTE_NUL;

	always_comb begin
		fb = fill_q;
		ob = ovf_q;
		put = 1'b0;
		pd = BYTE_NUL;
		lim = lim_bld;
		unique case (state_q)
			ST_IDLE: begin
				lim = lim_cur;
				if (in_fire && mode == MODE_END) begin
					fb = '0;
					ob = 1'b0;
				end
				if (in_fire && (mode == MODE_NAME || mode == MODE_INFO)) begin
					if (ready_q) begin
						fb = '0;
						ob = 1'b0;
					end
					if (mode == MODE_INFO && fb > lim) begin
						fb = lim;
						ob = 1'b1;
					end
					put = 1'b1;
					pd = (mode == MODE_NAME) ? name_byte : BYTE_NUL;
				end
			end
			ST_DIG: begin
				put = emit;
				pd = BYTE_ZERO_CHAR + {4'd0, dcnt_q};
			end
			ST_SPC: begin
				put = 1'b1;
				pd = BYTE_SPACE;
			end
			ST_CRC, ST_PULL: ;
			default: ;
		endcase
		put_ok = put && (fb < lim);
		fill_n = put_ok ? fb + CW'(1) : fb;
		ovf_n = ob | (put && !put_ok);
	end

	always_comb begin
		pull_last = 1'b0;
		if (ri_q == CW'(0))
			pull_byte = built_1k_q ? BYTE_STX : BYTE_SOH;
		else if (ri_q == CW'(1))
			pull_byte = BYTE_NUL;
		else if (ri_q == CW'(2))
			pull_byte = BYTE_FF;
		else if (ri_q < lim_bld + CW'(3))
			pull_byte = (pidx < fill_q) ? rdata_q : BYTE_NUL;
		else if (ri_q == lim_bld + CW'(3))
			pull_byte = crc_q[15:8];
		else begin
			pull_byte = crc_q[7:0];
			pull_last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (put_ok)
			mem[fb[AW-1:0]] <= pd;
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			ovf_q <= 1'b0;
			ready_q <= 1'b0;
			crc_q <= '0;
			ri_q <= '0;
			payload_1k_q <= 1'b0;
			built_1k_q <= 1'b0;
			out_valid_q <= 1'b0;
			crc_vld_s1 <= 1'b0;
		end else begin
			fill_q <= fill_n;
			ovf_q <= ovf_n;
			if (cfg_valid)
				payload_1k_q <= payload_1k;
			if (out_valid_q && out_ready && state_q != ST_PULL)
				out_valid_q <= 1'b0;
			crc_vld_s1 <= (state_q == ST_CRC) && (ci_q < lim_bld);
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (mode)
							MODE_NAME: begin
								if (ready_q) begin
									ready_q <= 1'b0;
									ri_q <= '0;
								end
							end
							MODE_INFO: begin
								ready_q <= 1'b0;
								ri_q <= '0;
								built_1k_q <= payload_1k_q;
								val_q <= file_size;
								time_q <= mod_time;
								k_q <= TOP_POW;
								dcnt_q <= '0;
								started_q <= 1'b0;
								which_q <= 1'b0;
								state_q <= ST_DIG;
							end
							MODE_END: begin
								crc_q <= '0;
								ri_q <= '0;
								ready_q <= 1'b1;
								built_1k_q <= payload_1k_q;
							end
							default: begin
								if (ready_q)
									state_q <= ST_PULL;
							end
						endcase
					end
				end
				ST_DIG: begin
					if (ge) begin
						val_q <= val_q - pw;
						dcnt_q <= dcnt_q + 4'd1;
					end else begin
						dcnt_q <= '0;
						if (emit)
							started_q <= 1'b1;
						if (k_q == 5'd0) begin
							if (!which_q)
								state_q <= ST_SPC;
							else begin
								ci_q <= '0;
								crc_q <= '0;
								state_q <= ST_CRC;
							end
						end else
							k_q <= k_q - 5'd1;
					end
				end
				ST_SPC: begin
					val_q <= time_q;
					k_q <= TOP_POW;
					started_q <= 1'b0;
					which_q <= 1'b1;
					state_q <= ST_DIG;
				end
				ST_CRC: begin
					if (ci_q < lim_bld) begin
						ci_q <= ci_q + CW'(1);
						crc_idx_s1 <= ci_q;
					end
					if (crc_vld_s1)
						crc_q <= crc_byte(crc_q, crc_in);
					else if (ci_q >= lim_bld) begin
						ready_q <= 1'b1;
						ri_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_PULL: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_byte_q <= pull_byte;
						out_last_q <= pull_last;
						out_trunc_q <= ovf_q;
						ri_q <= pull_last ? '0 : ri_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_PAYLOAD))
		else $error("fill count beyond store depth");

	a_pull_needs_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PULL) |-> ready_q)
		else $error("pull without a built packet");

	a_crc_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRC || state_q == ST_DIG) |-> !ready_q)
		else $error("packet marked ready during build");

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIG) |-> (dcnt_q <= 4'd9))
		else $error("decimal digit overflow");

endmodule
